>>> hw/rtl/smpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpu_pkg: shared types and constants
// Operation and status codes, stack sizes and channel payload structs.
// ----------------------------------------------------------------------------
package smpu_pkg;

  localparam int unsigned DataDepth = 64;
  localparam int unsigned RetDepth  = 32;
  localparam int unsigned DataAw    = $clog2(DataDepth);
  localparam int unsigned RetAw     = $clog2(RetDepth);
  localparam int unsigned DataCw    = $clog2(DataDepth + 1);
  localparam int unsigned RetCw     = $clog2(RetDepth + 1);
  localparam int unsigned WordW     = 64;
  localparam logic [WordW-1:0] SpaceChar = 64'd32;

  typedef enum logic [4:0] {
    OP_LIT      = 5'd0,
    OP_ADD      = 5'd1,
    OP_SUB      = 5'd2,
    OP_MUL      = 5'd3,
    OP_DIV      = 5'd4,
    OP_MOD      = 5'd5,
    OP_EQ       = 5'd6,
    OP_PICK     = 5'd7,
    OP_SWAP     = 5'd8,
    OP_SPACE    = 5'd9,
    OP_EMIT     = 5'd10,
    OP_PRINT    = 5'd11,
    OP_TO_RET   = 5'd12,
    OP_FROM_RET = 5'd13,
    OP_COPY_RET = 5'd14,
    OP_DROP_RET = 5'd15,
    OP_PUSH_RET = 5'd16
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUNDER  = 3'd1,
    ST_DOVER   = 3'd2,
    ST_RUNDER  = 3'd3,
    ST_ROVER   = 3'd4,
    ST_DIVZERO = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_CHAR = 2'd1,
    PK_NUM  = 2'd2
  } pkind_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_MUL, S_DIV, S_WB, S_TOP, S_TOPW, S_OUT
  } state_e;

  typedef struct packed {
    logic [4:0]        operation;
    logic signed [63:0] operand_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         print_kind;
    logic signed [63:0] print_value;
    logic signed [63:0] data_top;
    logic [6:0]         data_count;
    logic [5:0]         return_count;
  } out_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic is_mod;
  } div_ctl_t;

endpackage

>>> hw/rtl/smpu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpu_if: valid/ready channel
// Carries one beat of a payload struct between a source and a sink.
// ----------------------------------------------------------------------------
interface smpu_in_if;
  logic            valid;
  logic            ready;
  smpu_pkg::in_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface smpu_out_if;
  logic            valid;
  logic            ready;
  smpu_pkg::out_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/smpu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpu_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module smpu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write or read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/smpu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpu_div: signed truncating divider
// Restoring radix-2 on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smpu_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smpu_pkg::div_ctl_t    ctl_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  output logic                  done_o,
  output logic [63:0]           res_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, mod_q, mod_d, done_q, done_d;
  logic [64:0] trial;

  assign trial  = {rem_q, quo_q[63]} - {1'b0, den_q};
  assign done_o = done_q;
  assign res_o  = mod_q ? (neg_q ? 64'd0 - rem_q : rem_q)
                        : (neg_q ? 64'd0 - quo_q : quo_q);

  // one bit per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    mod_d  = mod_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      rem_d  = '0;
      quo_d  = a_i[63] ? 64'd0 - a_i : a_i;
      den_d  = b_i[63] ? 64'd0 - b_i : b_i;
      cnt_d  = 7'd0;
      busy_d = 1'b1;
      mod_d  = ctl_i.is_mod;
      neg_d  = ctl_i.is_mod ? a_i[63] : (a_i[63] ^ b_i[63]);
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    mod_q <= mod_d;
  end
endmodule

>>> hw/rtl/stack_machine_primitive_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_primitive_unit: stack machine primitive core
// Runs one primitive per beat on a data stack and a return stack in RAM.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_if    in   operation, operand_value
//  out_if   out  status, print_kind, print_value, data_top, data_count,
//                return_count
//
//  One item at a time; each item reads, executes, writes back, rereads the
//  top and loads the output, paced by the single RAM port of each stack (two
//  reads, up to two writes and a top-of-stack reread). Multiply adds steps for
//  32x32 partial products, divide/mod wait on the divider (one quotient bit per
//  cycle). Reset clears both stack pointers; no clearing pass. A result waits
//  in the output register while the next item runs; that item holds in its
//  output state until the register is free.
// ----------------------------------------------------------------------------
module stack_machine_primitive_unit (
  input logic       clk_i,
  input logic       rst_ni,
  smpu_in_if.sink   in_if,
  smpu_out_if.source out_if
);
  localparam int unsigned Aw  = smpu_pkg::DataAw;
  localparam int unsigned Rw  = smpu_pkg::RetAw;
  localparam int unsigned Cw  = smpu_pkg::DataCw;
  localparam int unsigned Rcw = smpu_pkg::RetCw;

  smpu_pkg::state_e state_q, state_d;
  logic [4:0]  op_q, op_d;
  logic [63:0] val_q, val_d;
  logic [Cw-1:0]  dp_q, dp_d;
  logic [Rcw-1:0] rp_q, rp_d;
  logic [63:0] b_q, b_d, a_q, a_d, r_q, r_d, r2_q, r2_d;
  logic [2:0]  st_q, st_d;
  logic [1:0]  pk_q, pk_d;
  logic [63:0] pv_q, pv_d;
  logic [63:0] top_q, top_d;
  logic [2:0]  step_q, step_d;
  logic        ovalid_q, ovalid_d;
  smpu_pkg::out_t out_q, out_d;
  // data RAM port
  logic            d_we;
  logic [Aw-1:0]   d_addr;
  logic [63:0]     d_wdata, d_rdata;
  // return RAM port
  logic            r_we;
  logic [Rw-1:0]   r_addr;
  logic [63:0]     r_wdata, r_rdata;
  // multiplier partial products
  logic [63:0]     pp_q, pp_d;
  // divider
  smpu_pkg::div_ctl_t div_ctl;
  logic            div_done;
  logic [63:0]     div_res;

  smpu_ram #(.Width(64), .Depth(smpu_pkg::DataDepth)) u_dram (
    .clk_i, .we_i(d_we), .addr_i(d_addr), .wdata_i(d_wdata), .rdata_o(d_rdata)
  );
  smpu_ram #(.Width(64), .Depth(smpu_pkg::RetDepth)) u_rram (
    .clk_i, .we_i(r_we), .addr_i(r_addr), .wdata_i(r_wdata), .rdata_o(r_rdata)
  );
  // dividend comes straight from the second data read, valid while starting
  smpu_div u_div (
    .clk_i, .rst_ni, .ctl_i(div_ctl), .a_i(d_rdata), .b_i(b_q),
    .done_o(div_done), .res_o(div_res)
  );

  assign in_if.ready    = (state_q == smpu_pkg::S_IDLE);
  assign out_if.valid   = ovalid_q;
  assign out_if.payload = out_q;

  // sequencer: read operands, execute, write back, refresh top
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    val_d    = val_q;
    dp_d     = dp_q;
    rp_d     = rp_q;
    b_d      = b_q;
    a_d      = a_q;
    r_d      = r_q;
    r2_d     = r2_q;
    st_d     = st_q;
    pk_d     = pk_q;
    pv_d     = pv_q;
    top_d    = top_q;
    step_d   = step_q;
    pp_d     = pp_q;
    ovalid_d = ovalid_q;
    out_d    = out_q;
    d_we     = 1'b0;
    d_addr   = Aw'(dp_q - Cw'(1));
    d_wdata  = '0;
    r_we     = 1'b0;
    r_addr   = Rw'(rp_q - Rcw'(1));
    r_wdata  = '0;
    div_ctl  = '{start: 1'b0, is_mod: 1'b0};
    if (ovalid_q && out_if.ready) ovalid_d = 1'b0;

    unique case (state_q)
      smpu_pkg::S_IDLE: begin
        if (in_if.valid) begin
          op_d   = in_if.payload.operation;
          val_d  = in_if.payload.operand_value;
          st_d   = smpu_pkg::ST_OK;
          pk_d   = smpu_pkg::PK_NONE;
          pv_d   = '0;
          state_d = smpu_pkg::S_RD1;
        end
      end
      // check counts, issue first reads (data top, return top)
      smpu_pkg::S_RD1: begin
        state_d = smpu_pkg::S_RD2;
        unique case (op_q)
          smpu_pkg::OP_LIT, smpu_pkg::OP_SPACE:
            if (dp_q >= Cw'(smpu_pkg::DataDepth)) st_d = smpu_pkg::ST_DOVER;
          smpu_pkg::OP_ADD, smpu_pkg::OP_SUB, smpu_pkg::OP_MUL, smpu_pkg::OP_DIV,
          smpu_pkg::OP_MOD, smpu_pkg::OP_EQ, smpu_pkg::OP_SWAP:
            if (dp_q < Cw'(2)) st_d = smpu_pkg::ST_DUNDER;
          smpu_pkg::OP_PICK, smpu_pkg::OP_EMIT, smpu_pkg::OP_PRINT:
            if (dp_q < Cw'(1)) st_d = smpu_pkg::ST_DUNDER;
          smpu_pkg::OP_TO_RET:
            if (dp_q < Cw'(1)) st_d = smpu_pkg::ST_DUNDER;
            else if (rp_q < Rcw'(1)) st_d = smpu_pkg::ST_RUNDER;
            else if (rp_q >= Rcw'(smpu_pkg::RetDepth)) st_d = smpu_pkg::ST_ROVER;
          smpu_pkg::OP_FROM_RET, smpu_pkg::OP_COPY_RET:
            if (rp_q < Rcw'(2)) st_d = smpu_pkg::ST_RUNDER;
            else if (dp_q >= Cw'(smpu_pkg::DataDepth)) st_d = smpu_pkg::ST_DOVER;
          smpu_pkg::OP_DROP_RET:
            if (rp_q < Rcw'(1)) st_d = smpu_pkg::ST_RUNDER;
          smpu_pkg::OP_PUSH_RET:
            if (rp_q >= Rcw'(smpu_pkg::RetDepth)) st_d = smpu_pkg::ST_ROVER;
          default: ;
        endcase
        // data top and return top
        d_addr = Aw'(dp_q - Cw'(1));
        r_addr = Rw'(rp_q - Rcw'(1));
      end
      // capture tops, read second entries
      smpu_pkg::S_RD2: begin
        b_d    = d_rdata;
        r_d    = r_rdata;
        d_addr = Aw'(dp_q - Cw'(2));
        r_addr = Rw'(rp_q - Rcw'(2));
        state_d = smpu_pkg::S_EXEC;
        if (op_q == smpu_pkg::OP_PICK && st_q == smpu_pkg::ST_OK) begin
          // n must be in [0, dp-2]; read the picked entry instead
          if (d_rdata[63] || d_rdata >= 64'(dp_q - Cw'(1))) begin
            st_d = smpu_pkg::ST_DUNDER;
          end else begin
            d_addr = Aw'(dp_q - Cw'(2) - Cw'(d_rdata[Cw-1:0]));
          end
        end
      end
      smpu_pkg::S_EXEC: begin
        a_d     = d_rdata;
        r2_d    = r_rdata;
        step_d  = 3'd0;
        state_d = smpu_pkg::S_WB;
        if (st_q == smpu_pkg::ST_OK) begin
          unique case (op_q)
            smpu_pkg::OP_ADD: r_d = d_rdata + b_q;
            smpu_pkg::OP_SUB: r_d = d_rdata - b_q;
            smpu_pkg::OP_EQ:  r_d = (d_rdata == b_q) ? 64'd1 : 64'd0;
            smpu_pkg::OP_MUL: begin
              pp_d = d_rdata[31:0] * b_q[31:0];
              state_d = smpu_pkg::S_MUL;
            end
            smpu_pkg::OP_DIV, smpu_pkg::OP_MOD: begin
              if (b_q == 64'd0) st_d = smpu_pkg::ST_DIVZERO;
              else begin
                div_ctl = '{start: 1'b1, is_mod: (op_q == smpu_pkg::OP_MOD)};
                state_d = smpu_pkg::S_DIV;
              end
            end
            smpu_pkg::OP_EMIT: begin
              pk_d = smpu_pkg::PK_CHAR;
              pv_d = {56'd0, b_q[7:0]};
            end
            smpu_pkg::OP_PRINT: begin
              pk_d = smpu_pkg::PK_NUM;
              pv_d = b_q;
            end
            default: ;
          endcase
        end
      end
      // low product plus two cross terms, one per cycle
      smpu_pkg::S_MUL: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: r_d = a_q[63:32] * b_q[31:0];
          3'd1: begin
            pp_d = pp_q + {r_q[31:0], 32'd0};
            r_d  = a_q[31:0] * b_q[63:32];
          end
          3'd2: begin
            r_d    = pp_q + {r_q[31:0], 32'd0};
            step_d = 3'd0;
            state_d = smpu_pkg::S_WB;
          end
          default: state_d = smpu_pkg::S_WB;
        endcase
      end
      smpu_pkg::S_DIV: begin
        if (div_done) begin
          r_d     = div_res;
          step_d  = 3'd0;
          state_d = smpu_pkg::S_WB;
        end
      end
      // writes, up to two per stack, the second in a repeat of this state
      smpu_pkg::S_WB: begin
        step_d = step_q + 3'd1;
        state_d = smpu_pkg::S_TOP;
        if (st_q == smpu_pkg::ST_OK) begin
          unique case (op_q)
            smpu_pkg::OP_LIT, smpu_pkg::OP_SPACE: begin
              d_we = 1'b1; d_addr = Aw'(dp_q);
              d_wdata = (op_q == smpu_pkg::OP_LIT) ? val_q : smpu_pkg::SpaceChar;
              dp_d = dp_q + Cw'(1);
            end
            smpu_pkg::OP_ADD, smpu_pkg::OP_SUB, smpu_pkg::OP_MUL, smpu_pkg::OP_DIV,
            smpu_pkg::OP_MOD, smpu_pkg::OP_EQ: begin
              d_we = 1'b1; d_addr = Aw'(dp_q - Cw'(2)); d_wdata = r_q;
              dp_d = dp_q - Cw'(1);
            end
            smpu_pkg::OP_PICK: begin
              d_we = 1'b1; d_addr = Aw'(dp_q - Cw'(1)); d_wdata = a_q;
            end
            smpu_pkg::OP_SWAP: begin
              if (step_q == 3'd0) begin
                d_we = 1'b1; d_addr = Aw'(dp_q - Cw'(1)); d_wdata = a_q;
                state_d = smpu_pkg::S_WB;
              end else begin
                d_we = 1'b1; d_addr = Aw'(dp_q - Cw'(2)); d_wdata = b_q;
              end
            end
            smpu_pkg::OP_EMIT, smpu_pkg::OP_PRINT: dp_d = dp_q - Cw'(1);
            smpu_pkg::OP_TO_RET: begin
              if (step_q == 3'd0) begin
                r_we = 1'b1; r_addr = Rw'(rp_q); r_wdata = r_q;
                state_d = smpu_pkg::S_WB;
              end else begin
                r_we = 1'b1; r_addr = Rw'(rp_q - Rcw'(1)); r_wdata = b_q;
                rp_d = rp_q + Rcw'(1);
                dp_d = dp_q - Cw'(1);
              end
            end
            smpu_pkg::OP_FROM_RET, smpu_pkg::OP_COPY_RET: begin
              d_we = 1'b1; d_addr = Aw'(dp_q); d_wdata = r2_q;
              dp_d = dp_q + Cw'(1);
              if (op_q == smpu_pkg::OP_FROM_RET) begin
                r_we = 1'b1; r_addr = Rw'(rp_q - Rcw'(2)); r_wdata = r_q;
                rp_d = rp_q - Rcw'(1);
              end
            end
            smpu_pkg::OP_DROP_RET: rp_d = rp_q - Rcw'(1);
            smpu_pkg::OP_PUSH_RET: begin
              r_we = 1'b1; r_addr = Rw'(rp_q); r_wdata = val_q;
              rp_d = rp_q + Rcw'(1);
            end
            default: ;
          endcase
        end
      end
      // reread data top
      smpu_pkg::S_TOP: begin
        d_addr  = Aw'(dp_q - Cw'(1));
        state_d = smpu_pkg::S_TOPW;
      end
      smpu_pkg::S_TOPW: begin
        top_d   = (dp_q == Cw'(0)) ? 64'd0 : d_rdata;
        state_d = smpu_pkg::S_OUT;
      end
      // load the output register once it is free
      smpu_pkg::S_OUT: begin
        if (!ovalid_q || out_if.ready) begin
          ovalid_d = 1'b1;
          out_d    = '{status: st_q, print_kind: pk_q, print_value: pv_q,
                       data_top: top_q,
                       data_count: 7'(dp_q), return_count: 6'(rp_q)};
          state_d  = smpu_pkg::S_IDLE;
        end
      end
      default: state_d = smpu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= smpu_pkg::S_IDLE;
      dp_q     <= '0;
      rp_q     <= '0;
      ovalid_q <= 1'b0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      dp_q     <= dp_d;
      rp_q     <= rp_d;
      ovalid_q <= ovalid_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    b_q   <= b_d;
    a_q   <= a_d;
    r_q   <= r_d;
    r2_q  <= r2_d;
    st_q  <= st_d;
    pk_q  <= pk_d;
    pv_q  <= pv_d;
    top_q <= top_d;
    pp_q  <= pp_d;
    out_q <= out_d;
  end
endmodule
